>>> rtl/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table: command codes, result
// status codes, controller states, index and read-address selects and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package slt_pkg;

  // Command codes on the operation field (code 3 behaves as a find)
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } res_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_DEL_RD,
    S_DEL_MOVE,
    S_RESULT
  } state_t;

  // Index register update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // Table read address relative to the index register
  typedef enum logic [1:0] {
    RD_BELOW,
    RD_AT,
    RD_ABOVE
  } rd_mode_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;       // capture the incoming transaction
    idx_op_t  idx_op;
    logic     rd_en;
    rd_mode_t rd_mode;
    logic     wr_en;      // write table at index
    logic     wr_value;   // 1: write captured value, 0: write read data
    logic     count_inc;
    logic     count_dec;
    logic     res_set;
    res_t     res_code;
    logic     out_load;
  } slt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_count;
    logic next_at_count;
    logic rdata_ge;
    logic rdata_eq;
    logic is_delete;
    logic out_free;
  } slt_stat_t;

endpackage

>>> rtl/slt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_ctrl
// Sequencer for the sorted list table: decodes each transaction, walks the
// table one entry at a time and hands the result to the output register.
// ----------------------------------------------------------------------------
module slt_ctrl import slt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [1:0] operation,
  input  slt_stat_t st,
  output slt_cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.rd_mode   = RD_AT;
    cmd.res_code  = ST_DONE;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (operation)
            OP_INSERT: begin
              if (st.full) begin
                cmd.res_set  = 1'b1;
                cmd.res_code = ST_FULL;
                state_next   = S_RESULT;
              end else begin
                cmd.idx_op = IDX_COUNT;
                state_next = S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (st.empty) begin
                cmd.res_set  = 1'b1;
                cmd.res_code = ST_EMPTY;
                state_next   = S_RESULT;
              end else begin
                cmd.idx_op = IDX_ZERO;
                state_next = S_FIND_RD;
              end
            end
            default: begin
              cmd.idx_op = IDX_ZERO;
              state_next = S_FIND_RD;
            end
          endcase
        end
      end

      // Insert: walk down from the top, moving larger-or-equal entries up
      S_INS_RD: begin
        if (st.idx_zero) begin
          state_next = S_INS_WR;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = RD_BELOW;
          state_next  = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (st.rdata_ge) begin
          cmd.wr_en  = 1'b1;
          cmd.idx_op = IDX_DEC;
          state_next = S_INS_RD;
        end else begin
          state_next = S_INS_WR;
        end
      end

      S_INS_WR: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_value  = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_code  = ST_DONE;
        state_next    = S_RESULT;
      end

      // Find and delete: scan upwards for the first equal entry
      S_FIND_RD: begin
        if (st.idx_at_count) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOTFOUND;
          state_next   = S_RESULT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = RD_AT;
          state_next  = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (st.rdata_eq) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_DONE;
          state_next   = st.is_delete ? S_DEL_RD : S_RESULT;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_FIND_RD;
        end
      end

      // Delete: close the gap by moving later entries down one place
      S_DEL_RD: begin
        if (st.next_at_count) begin
          cmd.count_dec = 1'b1;
          state_next    = S_RESULT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = RD_ABOVE;
          state_next  = S_DEL_MOVE;
        end
      end

      S_DEL_MOVE: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
        state_next = S_DEL_RD;
      end

      // Wait for the output register to take the result
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/slt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_datapath
// Entry table, index and count registers, comparators, result holding
// registers and the output register of the sorted list table.
// ----------------------------------------------------------------------------
module slt_datapath import slt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  slt_cmd_t   cmd,
  output slt_stat_t  st,
  input  logic [1:0] operation,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [4:0] position,
  output logic [4:0] entry_count,
  output logic [7:0] result_value
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rdata;
  logic [7:0]    val_q;
  logic          del_q;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [CW:0]   idx_plus;
  res_t          res_status;
  logic [CW-1:0] res_pos;
  logic [7:0]    res_value;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;

  // Read address relative to the index
  always_comb begin
    case (cmd.rd_mode)
      RD_BELOW: rd_idx = idx - CW'(1);
      RD_ABOVE: rd_idx = idx + CW'(1);
      default:  rd_idx = idx;
    endcase
  end

  // Entry table: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= cmd.wr_value ? val_q : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
  end

  // Captured transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_q <= value;
      del_q <= (operation == OP_DELETE);
    end
  end

  // Index register
  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      IDX_ZERO:  idx <= '0;
      IDX_COUNT: idx <= count;
      IDX_INC:   idx <= idx + CW'(1);
      IDX_DEC:   idx <= idx - CW'(1);
      default:   idx <= idx;
    endcase
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  // Result holding registers
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_pos    <= (cmd.res_code == ST_DONE) ? idx : '0;
      res_value  <= (cmd.res_code == ST_DONE) ? val_q : 8'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status;
      pos_ext      <= PW'(res_pos);
      cnt_ext      <= PW'(count);
      result_value <= res_value;
    end
  end

  assign position    = pos_ext[4:0];
  assign entry_count = cnt_ext[4:0];

  // Status back to the controller
  assign idx_plus         = {1'b0, idx} + (CW+1)'(1);
  assign st.full          = (count == CW'(CAPACITY));
  assign st.empty         = (count == '0);
  assign st.idx_zero      = (idx == '0);
  assign st.idx_at_count  = (idx >= count);
  assign st.next_at_count = (idx_plus >= {1'b0, count});
  assign st.rdata_ge      = (rdata >= val_q);
  assign st.rdata_eq      = (rdata == val_q);
  assign st.is_delete     = del_q;
  assign st.out_free      = !out_valid || !out_stall;

endmodule

>>> rtl/sorted_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table
// Bounded table of byte values kept in ascending order, with insert, delete
// and find commands, each giving one result transaction.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. The table sits in a single-port-style
// memory (one write and one registered read per cycle), so the sequencer
// visits one entry at a time, with a read state and then a compare or move
// state for each. An insert walks down from the top, moving each entry that
// is larger or equal up one place, and then writes the new value. A find
// scans upwards from the bottom until it meets an equal entry or reaches the
// count, and a delete then closes the gap by moving each later entry down. A
// full-table insert or an empty-table delete goes straight to the result. A
// stalled output register holds the sequencer in its result state until the
// result is handed over. A new command is taken as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
// No clearing pass is needed after reset.
module sorted_list_table import slt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [4:0] position,
  output logic [4:0] entry_count,
  output logic [7:0] result_value
);

  slt_cmd_t  cmd;
  slt_stat_t st;

  // Sequencer
  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .st        (st),
    .cmd       (cmd)
  );

  // Table and result path
  slt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .position     (position),
    .entry_count  (entry_count),
    .result_value (result_value)
  );

endmodule
